/* rtl/core/cpvf_pkg.sv */
// Shared types and constants of the class prediction vote filter.
// Holds the configuration register map, the register reset values and the
// structures passed between the core, the register file and the averaging unit.
`timescale 1ns / 1ps

package cpvf_pkg;

  localparam int LABEL_W    = 8;
  localparam int PROB_W     = 16;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int MIN_REP_W  = 2;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_MIN_REPEAT   = 3'd0;
  localparam logic [2:0] REG_GESTURE_THR  = 3'd1;
  localparam logic [2:0] REG_ROTATION_THR = 3'd2;
  localparam logic [2:0] REG_IDLE_LABEL   = 3'd3;
  localparam logic [2:0] REG_UNKNOWN_LBL  = 3'd4;
  localparam logic [2:0] REG_ROT_RIGHT    = 3'd5;
  localparam logic [2:0] REG_ROT_LEFT     = 3'd6;
  localparam logic [2:0] REG_LABEL_COUNT  = 3'd7;

  localparam logic [MIN_REP_W-1:0] RST_MIN_REPEAT   = 2'd2;
  localparam logic [PROB_W-1:0]    RST_GESTURE_THR  = 16'd52429;
  localparam logic [PROB_W-1:0]    RST_ROTATION_THR = 16'd45875;
  localparam logic [LABEL_W-1:0]   RST_IDLE_LABEL   = 8'd0;
  localparam logic [LABEL_W-1:0]   RST_UNKNOWN_LBL  = 8'd1;
  localparam logic [LABEL_W-1:0]   RST_ROT_RIGHT    = 8'd6;
  localparam logic [LABEL_W-1:0]   RST_ROT_LEFT     = 8'd7;
  localparam logic [LABEL_W-1:0]   RST_LABEL_COUNT  = 8'd8;

  typedef struct packed {
    logic [MIN_REP_W-1:0] min_run_len;
    logic [PROB_W-1:0]    gesture_threshold;
    logic [PROB_W-1:0]    rotation_threshold;
    logic [LABEL_W-1:0]   idle_label;
    logic [LABEL_W-1:0]   unknown_label;
    logic [LABEL_W-1:0]   rotate_right_label;
    logic [LABEL_W-1:0]   rotate_left_label;
    logic [LABEL_W-1:0]   label_count;
  } cfg_t;

  typedef struct packed {
    logic              done;
    logic [PROB_W-1:0] avg;
  } avg_rsp_t;

endpackage

/* rtl/core/cpvf_cfg_regs.sv */
// Configuration register file of the class prediction vote filter.
// APB-style write and read access; depends on cpvf_pkg for the register map.
`timescale 1ns / 1ps

module cpvf_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cpvf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [cpvf_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [cpvf_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output cpvf_pkg::cfg_t                     cfg_o
);
  import cpvf_pkg::*;

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_MIN_REPEAT:   cfg_d.min_run_len        = pwdata[MIN_REP_W-1:0];
        REG_GESTURE_THR:  cfg_d.gesture_threshold  = pwdata[PROB_W-1:0];
        REG_ROTATION_THR: cfg_d.rotation_threshold = pwdata[PROB_W-1:0];
        REG_IDLE_LABEL:   cfg_d.idle_label         = pwdata[LABEL_W-1:0];
        REG_UNKNOWN_LBL:  cfg_d.unknown_label      = pwdata[LABEL_W-1:0];
        REG_ROT_RIGHT:    cfg_d.rotate_right_label = pwdata[LABEL_W-1:0];
        REG_ROT_LEFT:     cfg_d.rotate_left_label  = pwdata[LABEL_W-1:0];
        REG_LABEL_COUNT:  cfg_d.label_count        = pwdata[LABEL_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_run_len        <= RST_MIN_REPEAT;
      cfg_q.gesture_threshold  <= RST_GESTURE_THR;
      cfg_q.rotation_threshold <= RST_ROTATION_THR;
      cfg_q.idle_label         <= RST_IDLE_LABEL;
      cfg_q.unknown_label      <= RST_UNKNOWN_LBL;
      cfg_q.rotate_right_label <= RST_ROT_RIGHT;
      cfg_q.rotate_left_label  <= RST_ROT_LEFT;
      cfg_q.label_count        <= RST_LABEL_COUNT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_MIN_REPEAT:   prdata = {{(CFG_DATA_W-MIN_REP_W){1'b0}}, cfg_q.min_run_len};
      REG_GESTURE_THR:  prdata = {{(CFG_DATA_W-PROB_W){1'b0}}, cfg_q.gesture_threshold};
      REG_ROTATION_THR: prdata = {{(CFG_DATA_W-PROB_W){1'b0}}, cfg_q.rotation_threshold};
      REG_IDLE_LABEL:   prdata = {{(CFG_DATA_W-LABEL_W){1'b0}}, cfg_q.idle_label};
      REG_UNKNOWN_LBL:  prdata = {{(CFG_DATA_W-LABEL_W){1'b0}}, cfg_q.unknown_label};
      REG_ROT_RIGHT:    prdata = {{(CFG_DATA_W-LABEL_W){1'b0}}, cfg_q.rotate_right_label};
      REG_ROT_LEFT:     prdata = {{(CFG_DATA_W-LABEL_W){1'b0}}, cfg_q.rotate_left_label};
      REG_LABEL_COUNT:  prdata = {{(CFG_DATA_W-LABEL_W){1'b0}}, cfg_q.label_count};
      default:          prdata = '0;
    endcase
  end

endmodule

/* rtl/core/cpvf_avg_unit.sv */
// Iterative averaging unit: sums the run history one entry per cycle, then
// divides by the run length one quotient bit per cycle on the same adder.
// Depends on cpvf_pkg for the probability width and the response structure.
`timescale 1ns / 1ps

module cpvf_avg_unit #(
  parameter int HistDepth = 3,
  localparam int CntW = $clog2(HistDepth + 1),
  localparam int IdxW = $clog2(HistDepth)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [CntW-1:0]               count_i,
  output logic [IdxW-1:0]               rd_idx_o,
  input  logic [cpvf_pkg::PROB_W-1:0]   rd_data_i,
  output cpvf_pkg::avg_rsp_t            rsp_o
);
  import cpvf_pkg::*;

  localparam int SumW  = PROB_W + $clog2(HistDepth);
  localparam int RemW  = CntW + 1;
  localparam int StepW = $clog2(PROB_W);

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_SUM  = 2'd1;
  localparam logic [1:0] A_DIV  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [SumW-1:0] acc_q, acc_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [StepW-1:0] step_q, step_d;
  logic            done_q, done_d;

  // The one shared adder/subtractor.
  logic            alu_sub;
  logic [SumW-1:0] alu_a, alu_b;
  logic [SumW:0]   alu_res;
  logic            borrow;
  logic [RemW-1:0] trial;

  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});
  assign borrow  = alu_res[SumW];
  assign trial   = {rem_q[RemW-2:0], acc_q[PROB_W-1]};

  assign rd_idx_o  = idx_q[IdxW-1:0];
  assign rsp_o.done = done_q;
  assign rsp_o.avg  = acc_q[PROB_W-1:0];

  always_comb begin
    alu_sub = 1'b0;
    alu_a   = acc_q;
    alu_b   = {{(SumW-PROB_W){1'b0}}, rd_data_i};
    if (state_q == A_DIV) begin
      alu_sub = 1'b1;
      alu_a   = {{(SumW-RemW){1'b0}}, trial};
      alu_b   = {{(SumW-CntW){1'b0}}, cnt_q};
    end
  end

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    step_d  = step_q;
    done_d  = 1'b0;
    case (state_q)
      A_IDLE: begin
        if (start_i) begin
          acc_d   = '0;
          idx_d   = '0;
          cnt_d   = count_i;
          state_d = A_SUM;
        end
      end
      A_SUM: begin
        acc_d = alu_res[SumW-1:0];
        idx_d = idx_q + CntW'(1);
        if ((idx_q + CntW'(1)) == cnt_q) begin
          // The average fits 16 bits, so the bits above are already below
          // the divisor and seed the remainder.
          rem_d   = {{(RemW-(SumW-PROB_W)){1'b0}}, alu_res[SumW-1:PROB_W]};
          step_d  = '0;
          state_d = A_DIV;
        end
      end
      A_DIV: begin
        rem_d = borrow ? trial : alu_res[RemW-1:0];
        acc_d = {acc_q[SumW-1:PROB_W], acc_q[PROB_W-2:0], ~borrow};
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(PROB_W - 1)) begin
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      idx_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    cnt_q <= cnt_d;
    rem_q <= rem_d;
  end

endmodule

/* rtl/core/class_prediction_vote_filter_core.sv */
// Top level of the class prediction vote filter: stream ports, run tracking,
// probability history and result register. Depends on cpvf_pkg, cpvf_cfg_regs
// and cpvf_avg_unit.
`timescale 1ns / 1ps

// The filter takes one classifier prediction word (label and Q0.16
// probability) and returns exactly one result word for it. Idle and unknown
// labels clear the current run and pass straight through; labels at or above
// label_count are flagged in tuser and reported as the unknown label; any other
// label extends its run, or starts a new one, and stores its probability in a
// history of HISTORY_DEPTH entries; a full history starts a new run. When the
// run reaches the configured minimum repeat count, the stored probabilities
// are averaged with truncating division and compared against the gesture or
// rotation threshold. An item that needs no average is classified, its result
// word registered and then loaded into the output register. For an item that
// needs one, a single adder first sums the run history one entry per cycle and
// then runs a 16-step restoring division on the same adder; then the word is
// classified, the average taken and the output register loaded. The input
// side is not ready while an item is at work and becomes ready in the same
// cycle the result appears, so a new word is taken only after the last one has
// its result. A finished result may wait in the output register while the next
// word is accepted. Configuration registers must only be written while no item
// is in flight.
module class_prediction_vote_filter_core #(
  parameter int HISTORY_DEPTH = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Prediction input. tdata: [7:0] class_label, [23:8] class_probability.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata,
  // Result output. tdata: [7:0] out_label, [23:8] out_probability.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [23:0]                         m_axis_tdata,
  // tuser: [0] label_error.
  output logic [0:0]                          m_axis_tuser,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cpvf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [cpvf_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [cpvf_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import cpvf_pkg::*;

  localparam int CntW = $clog2(HISTORY_DEPTH + 1);
  localparam int IdxW = $clog2(HISTORY_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  cfg_t     cfg;
  avg_rsp_t avg_rsp;

  logic [1:0] state_q, state_d;

  // Accepted prediction.
  logic [LABEL_W-1:0] lbl_q;
  logic [PROB_W-1:0]  prob_q;

  // Run state.
  logic [LABEL_W-1:0] run_label_q, run_label_d;
  logic [CntW-1:0]    run_len_q, run_len_d;
  logic [PROB_W-1:0]  hist_q [HISTORY_DEPTH];

  // Pending result, waiting for the output register.
  logic [LABEL_W-1:0] res_label_q, res_label_d;
  logic [PROB_W-1:0]  res_prob_q, res_prob_d;
  logic               res_err_q, res_err_d;

  // Output register.
  logic               m_valid_q, m_valid_d;
  logic [LABEL_W-1:0] m_label_q;
  logic [PROB_W-1:0]  m_prob_q;
  logic               m_err_q;

  logic               in_accept;
  logic               out_free;
  logic               out_load;

  logic               is_pass;
  logic               is_undef;
  logic               restart;
  logic [CntW-1:0]    wr_pos;
  logic [CntW-1:0]    new_len;
  logic               decide;
  logic               hist_we;
  logic               avg_start;
  logic [IdxW-1:0]    avg_rd_idx;
  logic               lbl_rot;
  logic [PROB_W-1:0]  thr;
  logic               avg_ok;
  logic [LABEL_W-1:0] dec_label;
  logic               dec_rot;

  cpvf_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cpvf_avg_unit #(
    .HistDepth (HISTORY_DEPTH)
  ) u_avg_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (avg_start),
    .count_i   (new_len),
    .rd_idx_o  (avg_rd_idx),
    .rd_data_i (hist_q[avg_rd_idx]),
    .rsp_o     (avg_rsp)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_valid_q | m_axis_tready;
  assign out_load      = (state_q == S_EMIT) & out_free;

  // Classification of the accepted label. Idle and unknown take precedence
  // over the undefined-label test.
  assign is_pass  = (lbl_q == cfg.unknown_label) || (lbl_q == cfg.idle_label);
  assign is_undef = (lbl_q >= cfg.label_count);

  // A full history or a change of label starts a new run at entry zero.
  assign restart = (run_len_q >= CntW'(HISTORY_DEPTH)) || (run_label_q != lbl_q);
  assign wr_pos  = restart ? '0 : run_len_q;
  assign new_len = wr_pos + CntW'(1);
  assign decide  = {{(LABEL_W-CntW){1'b0}}, new_len} >=
                   {{(LABEL_W-MIN_REP_W){1'b0}}, cfg.min_run_len};

  assign hist_we   = (state_q == S_EVAL) & ~is_pass & ~is_undef;
  assign avg_start = hist_we & decide;

  // Threshold decision on the finished average.
  assign lbl_rot   = (lbl_q == cfg.rotate_right_label) || (lbl_q == cfg.rotate_left_label);
  assign thr       = lbl_rot ? cfg.rotation_threshold : cfg.gesture_threshold;
  assign avg_ok    = (avg_rsp.avg >= thr);
  assign dec_label = avg_ok ? lbl_q : cfg.unknown_label;
  // The run survives a decision only when the reported label is a rotation.
  assign dec_rot   = (dec_label == cfg.rotate_right_label) ||
                     (dec_label == cfg.rotate_left_label);

  always_comb begin
    state_d     = state_q;
    run_label_d = run_label_q;
    run_len_d   = run_len_q;
    res_label_d = res_label_q;
    res_prob_d  = res_prob_q;
    res_err_d   = res_err_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        res_prob_d = prob_q;
        res_err_d  = 1'b0;
        if (is_pass) begin
          run_len_d   = '0;
          run_label_d = lbl_q;
          res_label_d = lbl_q;
          state_d     = S_EMIT;
        end else if (is_undef) begin
          res_label_d = cfg.unknown_label;
          res_err_d   = 1'b1;
          state_d     = S_EMIT;
        end else begin
          run_label_d = lbl_q;
          run_len_d   = new_len;
          if (decide) begin
            state_d = S_WAIT;
          end else begin
            res_label_d = cfg.unknown_label;
            state_d     = S_EMIT;
          end
        end
      end
      S_WAIT: begin
        if (avg_rsp.done) begin
          res_label_d = dec_label;
          res_prob_d  = avg_ok ? avg_rsp.avg : prob_q;
          res_err_d   = 1'b0;
          if (!dec_rot) begin
            run_len_d = '0;
          end
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_label_q <= '0;
      run_len_q   <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_label_q <= run_label_d;
      run_len_q   <= run_len_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      lbl_q  <= s_axis_tdata[7:0];
      prob_q <= s_axis_tdata[23:8];
    end
    if (hist_we) begin
      hist_q[wr_pos[IdxW-1:0]] <= prob_q;
    end
    res_label_q <= res_label_d;
    res_prob_q  <= res_prob_d;
    res_err_q   <= res_err_d;
    if (out_load) begin
      m_label_q <= res_label_q;
      m_prob_q  <= res_prob_q;
      m_err_q   <= res_err_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_prob_q, m_label_q};
  assign m_axis_tuser  = m_err_q;

endmodule

/* rtl/core/cpvf_checker.sv */
// Port-level checker for the class prediction vote filter core.
// Watches the stream ports only; bound to class_prediction_vote_filter_core.
`timescale 1ns / 1ps

module cpvf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending_q, pending_d;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;

  always_comb begin
    pending_d = pending_q;
    if (in_acc && !out_acc) begin
      pending_d = pending_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // The core works on one word at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input ready right after a word was accepted");

  // Every result belongs to an accepted prediction.
  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (pending_q != 2'd0))
    else $error("result delivered without an outstanding prediction");

  // One word at work plus one waiting in the output register at most.
  a_in_flight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more than two predictions in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind class_prediction_vote_filter_core cpvf_checker u_cpvf_checker (.*);
